// ===== hw/rtl/uv_sphere_vertex_generator_defines.svh =====
// ----------------------------------------------------------------------------
// UV sphere vertex generator: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define UVS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvs: implication check failed");
// next-cycle implication
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvs: next-cycle check failed");
`else
`define UVS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, types and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int MAX_LINES    = 64;
    localparam int TRIG_BITS    = 16;
    localparam int LINE_W       = 7;
    localparam int IDX_W        = 7;
    localparam int RADIUS_W     = 16;
    localparam int POS_W        = 17;
    localparam int TEX_W        = 17;
    localparam int CORNER_W     = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // reset values of the registers
    localparam int RADIUS_RESET = 256;
    localparam int LINES_RESET  = 60;

    // divider: integer bit plus fractional steps
    localparam int DIV_STEPS    = 32;
    localparam int QUO_W        = DIV_STEPS + 1;
    localparam int TEX_FRAC     = 16;
    localparam int PHI_FRAC     = 31;
    localparam int TEX_ONE      = 1 << TEX_FRAC;

    // CORDIC
    localparam int ATAN_STEPS   = 24;
    localparam int CORDIC_STEPS = (TRIG_BITS > ATAN_STEPS) ? ATAN_STEPS : TRIG_BITS;
    localparam int TRIG_SHIFT   = 31 - TRIG_BITS;
    localparam int PHASE_W      = 32;
    localparam int CORD_W       = 34;
    localparam int STEP_W       = 5;
    localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS     = 2'd0,
        REG_LAT_LINES  = 2'd1,
        REG_LONG_LINES = 2'd2
    } t_reg_idx;

    // item tag that rides along the whole chain
    typedef struct packed {
        logic [IDX_W-1:0] lat_idx;
        logic [IDX_W-1:0] long_idx;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             flip_phi;
        logic             flip_th;
    } t_side;

    // divider cell controls
    typedef struct packed {
        logic [LINE_W-1:0] n_lat;
        logic [LINE_W-1:0] n_long;
        logic              tap_tex;
        logic              tap_phi;
    } t_div_ctl;

    // divider cell payload: both divisions run side by side
    typedef struct packed {
        logic [LINE_W-1:0] rem_lat;
        logic [LINE_W-1:0] rem_long;
        logic [QUO_W-1:0]  quo_lat;
        logic [QUO_W-1:0]  quo_long;
        logic              rnd_tex_lat;
        logic              rnd_tex_long;
        logic              rnd_phi;
        t_side             side;
    } t_div;

    // CORDIC cell payload: phi and theta rotate side by side
    typedef struct packed {
        logic signed [CORD_W-1:0] x_phi;
        logic signed [CORD_W-1:0] y_phi;
        logic signed [CORD_W-1:0] z_phi;
        logic signed [CORD_W-1:0] x_th;
        logic signed [CORD_W-1:0] y_th;
        logic signed [CORD_W-1:0] z_th;
        t_side                    side;
    } t_cordic;

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic logic signed [CORD_W-1:0] atan_val(input logic [STEP_W-1:0] k);
        case (k)
            5'd0:    return 34'sh20000000;
            5'd1:    return 34'sh12E4051E;
            5'd2:    return 34'sh09FB385B;
            5'd3:    return 34'sh051111D4;
            5'd4:    return 34'sh028B0D43;
            5'd5:    return 34'sh0145D7E1;
            5'd6:    return 34'sh00A2F61E;
            5'd7:    return 34'sh00517C55;
            5'd8:    return 34'sh0028BE53;
            5'd9:    return 34'sh00145F2F;
            5'd10:   return 34'sh000A2F98;
            5'd11:   return 34'sh000517CC;
            5'd12:   return 34'sh00028BE6;
            5'd13:   return 34'sh000145F3;
            5'd14:   return 34'sh0000A2FA;
            5'd15:   return 34'sh0000517D;
            5'd16:   return 34'sh000028BE;
            5'd17:   return 34'sh0000145F;
            5'd18:   return 34'sh00000A30;
            5'd19:   return 34'sh00000518;
            5'd20:   return 34'sh0000028C;
            5'd21:   return 34'sh00000146;
            5'd22:   return 34'sh000000A3;
            5'd23:   return 34'sh00000051;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/uvs_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_div_cell
// One restoring-division step for the latitude and longitude quotients.
// ----------------------------------------------------------------------------
module uvs_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uvs_pkg::t_div_ctl i_ctl,
    input  logic              i_valid,
    output logic              o_ready,
    input  uvs_pkg::t_div     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output uvs_pkg::t_div     o_data
);

    logic          r_valid;
    uvs_pkg::t_div r_data;
    uvs_pkg::t_div n_data;

    // shifted remainders and quotient bits
    logic [uvs_pkg::LINE_W:0]   w_t_lat, w_t_long;
    logic                       w_b_lat, w_b_long;
    logic [uvs_pkg::LINE_W-1:0] w_r_lat, w_r_long;

    assign w_t_lat  = {i_data.rem_lat, 1'b0};
    assign w_t_long = {i_data.rem_long, 1'b0};
    assign w_b_lat  = (w_t_lat >= {1'b0, i_ctl.n_lat});
    assign w_b_long = (w_t_long >= {1'b0, i_ctl.n_long});
    assign w_r_lat  = w_b_lat ? uvs_pkg::LINE_W'(w_t_lat - {1'b0, i_ctl.n_lat})
                              : uvs_pkg::LINE_W'(w_t_lat);
    assign w_r_long = w_b_long ? uvs_pkg::LINE_W'(w_t_long - {1'b0, i_ctl.n_long})
                               : uvs_pkg::LINE_W'(w_t_long);

    // step result; round-half-up flags are captured at the tap positions
    always_comb begin
        n_data          = i_data;
        n_data.rem_lat  = w_r_lat;
        n_data.rem_long = w_r_long;
        n_data.quo_lat  = {i_data.quo_lat[uvs_pkg::QUO_W-2:0], w_b_lat};
        n_data.quo_long = {i_data.quo_long[uvs_pkg::QUO_W-2:0], w_b_long};
        if (i_ctl.tap_tex) begin
            n_data.rnd_tex_lat  = ({1'b0, w_r_lat} + {2'b0, i_ctl.n_lat[uvs_pkg::LINE_W-1:1]})
                                  >= {1'b0, i_ctl.n_lat};
            n_data.rnd_tex_long = ({1'b0, w_r_long} + {2'b0, i_ctl.n_long[uvs_pkg::LINE_W-1:1]})
                                  >= {1'b0, i_ctl.n_long};
        end
        if (i_ctl.tap_phi) begin
            n_data.rnd_phi = ({1'b0, w_r_lat} + {2'b0, i_ctl.n_lat[uvs_pkg::LINE_W-1:1]})
                             >= {1'b0, i_ctl.n_lat};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/uvs_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One CORDIC rotation step for the phi and theta angles.
// ----------------------------------------------------------------------------
module uvs_cordic_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [uvs_pkg::STEP_W-1:0] i_step,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  uvs_pkg::t_cordic           i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output uvs_pkg::t_cordic           o_data
);

    logic                     r_valid;
    uvs_pkg::t_cordic         r_data;
    uvs_pkg::t_cordic         n_data;
    logic signed [uvs_pkg::CORD_W-1:0] w_atan;

    assign w_atan = uvs_pkg::atan_val(i_step);

    // rotate toward z = 0, floor shifts
    always_comb begin
        n_data = i_data;
        if (!i_data.z_phi[uvs_pkg::CORD_W-1]) begin
            n_data.x_phi = i_data.x_phi - (i_data.y_phi >>> i_step);
            n_data.y_phi = i_data.y_phi + (i_data.x_phi >>> i_step);
            n_data.z_phi = i_data.z_phi - w_atan;
        end else begin
            n_data.x_phi = i_data.x_phi + (i_data.y_phi >>> i_step);
            n_data.y_phi = i_data.y_phi - (i_data.x_phi >>> i_step);
            n_data.z_phi = i_data.z_phi + w_atan;
        end
        if (!i_data.z_th[uvs_pkg::CORD_W-1]) begin
            n_data.x_th = i_data.x_th - (i_data.y_th >>> i_step);
            n_data.y_th = i_data.y_th + (i_data.x_th >>> i_step);
            n_data.z_th = i_data.z_th - w_atan;
        end else begin
            n_data.x_th = i_data.x_th + (i_data.y_th >>> i_step);
            n_data.y_th = i_data.y_th - (i_data.x_th >>> i_step);
            n_data.z_th = i_data.z_th + w_atan;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// UV sphere vertex, normal, texture coordinate and quad index generator.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  in       | input     | i_in_valid / o_in_ready   | lat_index, long_index
//  out      | output    | o_out_valid / i_out_ready | pos, tex, range, corners
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  One grid point per cycle sustained while the output is not stalled;
//  stages: front stage, 32 divider cells, phase stage, 16 CORDIC cells,
//  trig rounding, two multiply stages and the output register.
//  Every stage has its own valid bit; a stall at the output backs up only
//  stages that hold an item, so bubbles are squeezed out.
//  Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "uv_sphere_vertex_generator_defines.svh"

module uv_sphere_vertex_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [uvs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [uvs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [uvs_pkg::IDX_W-1:0]           i_lat_index,
    input  logic [uvs_pkg::IDX_W-1:0]           i_long_index,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [uvs_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]    o_pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]    o_pos_z,
    output logic [uvs_pkg::TEX_W-1:0]           o_tex_u,
    output logic [uvs_pkg::TEX_W-1:0]           o_tex_v,
    output logic                                o_in_range,
    output logic                                o_quad_valid,
    output logic [uvs_pkg::CORNER_W-1:0]        o_corner_a,
    output logic [uvs_pkg::CORNER_W-1:0]        o_corner_b,
    output logic [uvs_pkg::CORNER_W-1:0]        o_corner_c,
    output logic [uvs_pkg::CORNER_W-1:0]        o_corner_d
);

    localparam int TB     = uvs_pkg::TRIG_BITS;
    localparam int FRAC   = TB - 1;
    localparam int PROD1_W = uvs_pkg::RADIUS_W + 1 + TB;
    localparam int PROD2_W = PROD1_W + TB;
    localparam int FULL_W = 16;
    localparam logic signed [TB-1:0] TRIG_MAX = TB'((1 << (TB - 1)) - 1);
    localparam logic signed [TB-1:0] TRIG_MIN = -TRIG_MAX - TB'(1);
    localparam logic signed [uvs_pkg::CORD_W-1:0] TRIG_HALF =
        uvs_pkg::CORD_W'(1 << (uvs_pkg::TRIG_SHIFT - 1));
    localparam logic signed [PROD1_W-1:0] HALF1 = PROD1_W'(1 << (FRAC - 1));
    localparam logic signed [PROD2_W-1:0] HALF2 = PROD2_W'(1) <<< (2 * FRAC - 1);
    localparam logic signed [PROD2_W-1:0] POS_MAX = PROD2_W'(65535);

    typedef struct packed {
        logic signed [TB-1:0] cp;
        logic signed [TB-1:0] sp;
        logic signed [TB-1:0] ct;
        logic signed [TB-1:0] st;
        uvs_pkg::t_side       side;
    } t_trig;

    typedef struct packed {
        logic signed [PROD1_W-1:0] rsp;
        logic signed [PROD1_W-1:0] rcp;
        logic signed [TB-1:0]      ct;
        logic signed [TB-1:0]      st;
        uvs_pkg::t_side            side;
    } t_mul1;

    typedef struct packed {
        logic signed [PROD2_W-1:0]         px;
        logic signed [PROD2_W-1:0]         pz;
        logic signed [uvs_pkg::POS_W-1:0]  py;
        uvs_pkg::t_side                    side;
    } t_mul2;

    // round to Q1.(TB-1), apply quadrant sign, saturate
    function automatic logic signed [TB-1:0] trig_round(
        input logic signed [uvs_pkg::CORD_W-1:0] v,
        input logic                              flip
    );
        logic signed [uvs_pkg::CORD_W-1:0] t;
        t = (v + TRIG_HALF) >>> uvs_pkg::TRIG_SHIFT;
        if (flip) begin
            t = -t;
        end
        if (t > uvs_pkg::CORD_W'(TRIG_MAX)) begin
            return TRIG_MAX;
        end else if (t < uvs_pkg::CORD_W'(TRIG_MIN)) begin
            return TRIG_MIN;
        end
        return TB'(t);
    endfunction

    // saturate a position to +-65535
    function automatic logic signed [uvs_pkg::POS_W-1:0] sat_pos(
        input logic signed [PROD2_W-1:0] v
    );
        if (v > POS_MAX) begin
            return uvs_pkg::POS_W'(POS_MAX);
        end else if (v < -POS_MAX) begin
            return uvs_pkg::POS_W'(-POS_MAX);
        end
        return uvs_pkg::POS_W'(v);
    endfunction

    // configuration registers
    logic [uvs_pkg::RADIUS_W-1:0] r_radius;
    logic [uvs_pkg::LINE_W-1:0]   r_lat_lines, r_long_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= uvs_pkg::RADIUS_W'(uvs_pkg::RADIUS_RESET);
            r_lat_lines  <= uvs_pkg::LINE_W'(uvs_pkg::LINES_RESET);
            r_long_lines <= uvs_pkg::LINE_W'(uvs_pkg::LINES_RESET);
        end else if (i_cfg_we) begin
            case (uvs_pkg::t_reg_idx'(i_cfg_idx))
                uvs_pkg::REG_RADIUS:     r_radius     <= i_cfg_data[uvs_pkg::RADIUS_W-1:0];
                uvs_pkg::REG_LAT_LINES:  r_lat_lines  <= i_cfg_data[uvs_pkg::LINE_W-1:0];
                uvs_pkg::REG_LONG_LINES: r_long_lines <= i_cfg_data[uvs_pkg::LINE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective line counts: zero acts as one, clipped to the maximum
    logic [uvs_pkg::LINE_W-1:0] w_n_lat, w_n_long;

    assign w_n_lat  = (r_lat_lines == '0) ? uvs_pkg::LINE_W'(1) :
                      (r_lat_lines > uvs_pkg::LINE_W'(uvs_pkg::MAX_LINES)) ?
                      uvs_pkg::LINE_W'(uvs_pkg::MAX_LINES) : r_lat_lines;
    assign w_n_long = (r_long_lines == '0) ? uvs_pkg::LINE_W'(1) :
                      (r_long_lines > uvs_pkg::LINE_W'(uvs_pkg::MAX_LINES)) ?
                      uvs_pkg::LINE_W'(uvs_pkg::MAX_LINES) : r_long_lines;

    // divider chain wiring; index 0 is the front stage
    uvs_pkg::t_div w_div_data [0:uvs_pkg::DIV_STEPS];
    logic          w_div_valid[0:uvs_pkg::DIV_STEPS];
    logic          w_div_ready[0:uvs_pkg::DIV_STEPS];

    // front stage: integer quotient bit and first remainder
    logic          r_f_valid;
    uvs_pkg::t_div r_f_data;
    uvs_pkg::t_div n_f_data;
    logic          w_qi_lat, w_qi_long;

    assign w_qi_lat  = (i_lat_index >= w_n_lat);
    assign w_qi_long = (i_long_index >= w_n_long);

    always_comb begin
        n_f_data               = '0;
        n_f_data.rem_lat       = w_qi_lat ? (i_lat_index - w_n_lat) : i_lat_index;
        n_f_data.rem_long      = w_qi_long ? (i_long_index - w_n_long) : i_long_index;
        n_f_data.quo_lat       = uvs_pkg::QUO_W'(w_qi_lat);
        n_f_data.quo_long      = uvs_pkg::QUO_W'(w_qi_long);
        n_f_data.side.lat_idx  = i_lat_index;
        n_f_data.side.long_idx = i_long_index;
    end

    assign o_in_ready = !r_f_valid || w_div_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_f_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_f_data <= n_f_data;
        end
    end

    assign w_div_valid[0] = r_f_valid;
    assign w_div_data[0]  = r_f_data;

    // fractional division steps
    genvar g;
    generate
        for (g = 0; g < uvs_pkg::DIV_STEPS; g++) begin : g_div
            uvs_pkg::t_div_ctl w_ctl;
            assign w_ctl.n_lat   = w_n_lat;
            assign w_ctl.n_long  = w_n_long;
            assign w_ctl.tap_tex = (g == uvs_pkg::TEX_FRAC - 1);
            assign w_ctl.tap_phi = (g == uvs_pkg::PHI_FRAC - 1);

            uvs_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_valid (w_div_valid[g]),
                .o_ready (w_div_ready[g]),
                .i_data  (w_div_data[g]),
                .o_valid (w_div_valid[g+1]),
                .i_ready (w_div_ready[g+1]),
                .o_data  (w_div_data[g+1])
            );
        end
    endgenerate

    // CORDIC chain wiring; index 0 is the phase stage
    uvs_pkg::t_cordic w_cor_data [0:uvs_pkg::CORDIC_STEPS];
    logic             w_cor_valid[0:uvs_pkg::CORDIC_STEPS];
    logic             w_cor_ready[0:uvs_pkg::CORDIC_STEPS];

    // phase stage: rounded phases, texture coordinates, quadrant fold
    logic             r_p_valid;
    uvs_pkg::t_cordic r_p_data;
    uvs_pkg::t_cordic n_p_data;
    uvs_pkg::t_div    w_dq;
    logic                        w_rnd_th;
    logic [uvs_pkg::PHASE_W-1:0] w_ph_phi, w_ph_th, w_zb_phi, w_zb_th;
    logic [uvs_pkg::TEX_W:0]     w_q_u, w_q_v;
    logic                        w_flip_phi, w_flip_th;

    assign w_dq     = w_div_data[uvs_pkg::DIV_STEPS];
    assign w_rnd_th = ({1'b0, w_dq.rem_long} + {2'b0, w_n_long[uvs_pkg::LINE_W-1:1]})
                      >= {1'b0, w_n_long};
    assign w_ph_phi = w_dq.quo_lat[uvs_pkg::QUO_W-1:1] + uvs_pkg::PHASE_W'(w_dq.rnd_phi);
    assign w_ph_th  = w_dq.quo_long[uvs_pkg::PHASE_W-1:0] + uvs_pkg::PHASE_W'(w_rnd_th);
    assign w_q_u    = {1'b0, w_dq.quo_long[uvs_pkg::QUO_W-1:uvs_pkg::TEX_FRAC]}
                      + (uvs_pkg::TEX_W+1)'(w_dq.rnd_tex_long);
    assign w_q_v    = {1'b0, w_dq.quo_lat[uvs_pkg::QUO_W-1:uvs_pkg::TEX_FRAC]}
                      + (uvs_pkg::TEX_W+1)'(w_dq.rnd_tex_lat);

    // second and third quadrants rotate by a half turn
    assign w_flip_phi = w_ph_phi[uvs_pkg::PHASE_W-1] ^ w_ph_phi[uvs_pkg::PHASE_W-2];
    assign w_flip_th  = w_ph_th[uvs_pkg::PHASE_W-1] ^ w_ph_th[uvs_pkg::PHASE_W-2];
    assign w_zb_phi   = {w_ph_phi[uvs_pkg::PHASE_W-1] ^ w_flip_phi,
                         w_ph_phi[uvs_pkg::PHASE_W-2:0]};
    assign w_zb_th    = {w_ph_th[uvs_pkg::PHASE_W-1] ^ w_flip_th,
                         w_ph_th[uvs_pkg::PHASE_W-2:0]};

    always_comb begin
        n_p_data       = '0;
        n_p_data.x_phi = uvs_pkg::CORDIC_START;
        n_p_data.x_th  = uvs_pkg::CORDIC_START;
        n_p_data.z_phi = {{(uvs_pkg::CORD_W-uvs_pkg::PHASE_W){w_zb_phi[uvs_pkg::PHASE_W-1]}},
                          w_zb_phi};
        n_p_data.z_th  = {{(uvs_pkg::CORD_W-uvs_pkg::PHASE_W){w_zb_th[uvs_pkg::PHASE_W-1]}},
                          w_zb_th};
        n_p_data.side  = w_dq.side;
        n_p_data.side.tex_u = (w_q_u >= (uvs_pkg::TEX_W+1)'(uvs_pkg::TEX_ONE)) ? '0 :
            uvs_pkg::TEX_W'((uvs_pkg::TEX_W+1)'(uvs_pkg::TEX_ONE) - w_q_u);
        n_p_data.side.tex_v = (w_q_v >= (uvs_pkg::TEX_W+1)'(uvs_pkg::TEX_ONE)) ? '0 :
            uvs_pkg::TEX_W'((uvs_pkg::TEX_W+1)'(uvs_pkg::TEX_ONE) - w_q_v);
        n_p_data.side.flip_phi = w_flip_phi;
        n_p_data.side.flip_th  = w_flip_th;
    end

    assign w_div_ready[uvs_pkg::DIV_STEPS] = !r_p_valid || w_cor_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_div_ready[uvs_pkg::DIV_STEPS]) begin
            r_p_valid <= w_div_valid[uvs_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_ready[uvs_pkg::DIV_STEPS] && w_div_valid[uvs_pkg::DIV_STEPS]) begin
            r_p_data <= n_p_data;
        end
    end

    assign w_cor_valid[0] = r_p_valid;
    assign w_cor_data[0]  = r_p_data;

    // CORDIC rotation steps
    generate
        for (g = 0; g < uvs_pkg::CORDIC_STEPS; g++) begin : g_cordic
            uvs_cordic_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_step  (uvs_pkg::STEP_W'(g)),
                .i_valid (w_cor_valid[g]),
                .o_ready (w_cor_ready[g]),
                .i_data  (w_cor_data[g]),
                .o_valid (w_cor_valid[g+1]),
                .i_ready (w_cor_ready[g+1]),
                .o_data  (w_cor_data[g+1])
            );
        end
    endgenerate

    // trig rounding stage
    logic             r_t_valid, w_t_ready;
    t_trig            r_t_data;
    uvs_pkg::t_cordic w_cq;

    assign w_cq = w_cor_data[uvs_pkg::CORDIC_STEPS];
    assign w_cor_ready[uvs_pkg::CORDIC_STEPS] = w_t_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_t_ready) begin
            r_t_valid <= w_cor_valid[uvs_pkg::CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_t_ready && w_cor_valid[uvs_pkg::CORDIC_STEPS]) begin
            r_t_data.cp   <= trig_round(w_cq.x_phi, w_cq.side.flip_phi);
            r_t_data.sp   <= trig_round(w_cq.y_phi, w_cq.side.flip_phi);
            r_t_data.ct   <= trig_round(w_cq.x_th, w_cq.side.flip_th);
            r_t_data.st   <= trig_round(w_cq.y_th, w_cq.side.flip_th);
            r_t_data.side <= w_cq.side;
        end
    end

    // first multiply: radius by sin(phi) and cos(phi)
    logic  r_m1_valid, w_m1_ready;
    t_mul1 r_m1_data;
    logic signed [uvs_pkg::RADIUS_W:0] w_r_s;

    assign w_r_s     = {1'b0, r_radius};
    assign w_t_ready = !r_t_valid || w_m1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (w_m1_ready) begin
            r_m1_valid <= r_t_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m1_ready && r_t_valid) begin
            r_m1_data.rsp  <= PROD1_W'(w_r_s) * PROD1_W'(r_t_data.sp);
            r_m1_data.rcp  <= PROD1_W'(w_r_s) * PROD1_W'(r_t_data.cp);
            r_m1_data.ct   <= r_t_data.ct;
            r_m1_data.st   <= r_t_data.st;
            r_m1_data.side <= r_t_data.side;
        end
    end

    // second multiply: r*sin(phi) by cos/sin(theta); y finishes here
    logic  r_m2_valid, w_m2_ready;
    t_mul2 r_m2_data;
    logic signed [PROD1_W-1:0] w_py_full;

    assign w_py_full  = (r_m1_data.rcp + HALF1) >>> FRAC;
    assign w_m1_ready = !r_m1_valid || w_m2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (w_m2_ready) begin
            r_m2_valid <= r_m1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m2_ready && r_m1_valid) begin
            r_m2_data.px   <= PROD2_W'(r_m1_data.rsp) * PROD2_W'(r_m1_data.ct);
            r_m2_data.pz   <= PROD2_W'(r_m1_data.rsp) * PROD2_W'(r_m1_data.st);
            r_m2_data.py   <= sat_pos(PROD2_W'(w_py_full));
            r_m2_data.side <= r_m1_data.side;
        end
    end

    // output stage: final rounding, range flags, quad corners
    logic                              r_o_valid;
    logic signed [uvs_pkg::POS_W-1:0]  r_pos_x, r_pos_y, r_pos_z;
    logic [uvs_pkg::TEX_W-1:0]         r_tex_u, r_tex_v;
    logic                              r_in_range, r_quad_valid;
    logic [uvs_pkg::CORNER_W-1:0]      r_corner_a, r_corner_b, r_corner_c, r_corner_d;

    logic                       w_in_range, w_quad;
    logic [uvs_pkg::LINE_W:0]   w_np1;
    logic [FULL_W-1:0]          w_a, w_b;
    logic signed [PROD2_W-1:0]  w_px_full, w_pz_full;

    assign w_in_range = (r_m2_data.side.lat_idx <= w_n_lat)
                     && (r_m2_data.side.long_idx <= w_n_long);
    assign w_quad     = (r_m2_data.side.lat_idx < w_n_lat)
                     && (r_m2_data.side.long_idx < w_n_long);
    assign w_np1      = {1'b0, w_n_long} + (uvs_pkg::LINE_W+1)'(1);
    assign w_a        = FULL_W'(r_m2_data.side.lat_idx) * FULL_W'(w_np1)
                      + FULL_W'(r_m2_data.side.long_idx);
    assign w_b        = w_a + FULL_W'(w_np1);
    assign w_px_full  = (r_m2_data.px + HALF2) >>> (2 * FRAC);
    assign w_pz_full  = (r_m2_data.pz + HALF2) >>> (2 * FRAC);
    assign w_m2_ready = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_m2_ready) begin
            r_o_valid <= r_m2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m2_ready && r_m2_valid) begin
            r_in_range   <= w_in_range;
            r_quad_valid <= w_in_range && w_quad;
            r_pos_x      <= w_in_range ? sat_pos(w_px_full) : '0;
            r_pos_y      <= w_in_range ? r_m2_data.py : '0;
            r_pos_z      <= w_in_range ? sat_pos(w_pz_full) : '0;
            r_tex_u      <= w_in_range ? r_m2_data.side.tex_u : '0;
            r_tex_v      <= w_in_range ? r_m2_data.side.tex_v : '0;
            r_corner_a   <= (w_in_range && w_quad) ? uvs_pkg::CORNER_W'(w_a) : '0;
            r_corner_b   <= (w_in_range && w_quad) ? uvs_pkg::CORNER_W'(w_b) : '0;
            r_corner_c   <= (w_in_range && w_quad) ? uvs_pkg::CORNER_W'(w_a + FULL_W'(1)) : '0;
            r_corner_d   <= (w_in_range && w_quad) ? uvs_pkg::CORNER_W'(w_b + FULL_W'(1)) : '0;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_pos_z      = r_pos_z;
    assign o_tex_u      = r_tex_u;
    assign o_tex_v      = r_tex_v;
    assign o_in_range   = r_in_range;
    assign o_quad_valid = r_quad_valid;
    assign o_corner_a   = r_corner_a;
    assign o_corner_b   = r_corner_b;
    assign o_corner_c   = r_corner_c;
    assign o_corner_d   = r_corner_d;

    // checks
    `UVS_ASSERT_IMPLY(a_full_when_blocked, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    `UVS_ASSERT_IMPLY(a_quad_in_range, i_clk, i_rst_n, o_out_valid && o_quad_valid, o_in_range)
    `UVS_ASSERT_IMPLY(a_out_of_range_zero, i_clk, i_rst_n,
        o_out_valid && !o_in_range,
        (o_pos_x == '0) && (o_pos_y == '0) && (o_pos_z == '0) &&
        (o_tex_u == '0) && (o_tex_v == '0) && (o_corner_a == '0))
    `UVS_ASSERT_IMPLY(a_corner_steps, i_clk, i_rst_n,
        o_out_valid && o_quad_valid,
        (o_corner_c == o_corner_a + uvs_pkg::CORNER_W'(1)) &&
        (o_corner_d == o_corner_b + uvs_pkg::CORNER_W'(1)))
    `UVS_ASSERT_NEXT(a_drain_empties, i_clk, i_rst_n,
        r_o_valid && i_out_ready && !r_m2_valid, !r_o_valid)

endmodule
